// File: rtl/core/crs_pkg.sv
// Package: types, constants and codes of the cutdown release sequencer.
package crs_pkg;

  // Timer reload width and countdown width (one extra bit for the wrap).
  localparam int unsigned TIMER_BITS = 12;
  localparam int unsigned CNT_BITS   = TIMER_BITS + 1;

  // Configuration port geometry.
  localparam int unsigned ADDR_BITS  = 5;
  localparam int unsigned DATA_BITS  = 32;
  localparam int unsigned IDX_BITS   = ADDR_BITS - 2;

  // Register indexes.
  localparam logic [IDX_BITS-1:0] REG_CHANNEL_REVERSED = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_PULSE_THRESHOLD  = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_TRIGGER_MODE     = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_CONFIRM_TICKS    = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_PULSE_TICKS      = 3'd4;

  // Register reset values.
  localparam logic [15:0]           THRESH_RESET  = 16'd3000;
  localparam logic [TIMER_BITS-1:0] CONFIRM_RESET = TIMER_BITS'(20);
  localparam logic [TIMER_BITS-1:0] PULSE_RESET   = TIMER_BITS'(120);

  // Phase codes.
  localparam logic [2:0] PH_ASCENT  = 3'd0;
  localparam logic [2:0] PH_CONFIRM = 3'd1;
  localparam logic [2:0] PH_FIRING  = 3'd2;
  localparam logic [2:0] PH_END     = 3'd3;
  localparam logic [2:0] PH_WAIT    = 3'd4;

  typedef struct packed {
    logic                  channel_reversed;
    logic [15:0]           pulse_threshold;
    logic                  trigger_mode;
    logic [TIMER_BITS-1:0] confirm_ticks;
    logic [TIMER_BITS-1:0] pulse_ticks;
  } cfg_t;

  typedef struct packed {
    logic [15:0] pulse_width;
    logic        radio_present;
  } in_item_t;

  typedef struct packed {
    logic       fire_out;
    logic       led_level;
    logic [2:0] phase;
    logic       manual_command;
  } out_item_t;

endpackage

// File: rtl/core/crs_cfg_regs.sv
// Configuration register file with an APB-style write and read port.
module crs_cfg_regs
  import crs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [ADDR_BITS-1:0] paddr_i,
  input  logic [DATA_BITS-1:0] pwdata_i,
  output logic [DATA_BITS-1:0] prdata_o,
  output logic                 pready_o,
  output cfg_t                 cfg_o
);

  cfg_t                cfg_q;
  logic                wr_en;
  logic [IDX_BITS-1:0] idx;

  assign pready_o = 1'b1;
  assign idx      = paddr_i[ADDR_BITS-1:2];
  assign wr_en    = psel_i & penable_i & pwrite_i;

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_reversed <= 1'b0;
      cfg_q.pulse_threshold  <= THRESH_RESET;
      cfg_q.trigger_mode     <= 1'b0;
      cfg_q.confirm_ticks    <= CONFIRM_RESET;
      cfg_q.pulse_ticks      <= PULSE_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_CHANNEL_REVERSED: cfg_q.channel_reversed <= pwdata_i[0];
        REG_PULSE_THRESHOLD:  cfg_q.pulse_threshold  <= pwdata_i[15:0];
        REG_TRIGGER_MODE:     cfg_q.trigger_mode     <= pwdata_i[0];
        REG_CONFIRM_TICKS:    cfg_q.confirm_ticks    <= pwdata_i[TIMER_BITS-1:0];
        REG_PULSE_TICKS:      cfg_q.pulse_ticks      <= pwdata_i[TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register on a read
  always_comb begin
    prdata_o = '0;
    case (idx)
      REG_CHANNEL_REVERSED: prdata_o = DATA_BITS'(cfg_q.channel_reversed);
      REG_PULSE_THRESHOLD:  prdata_o = DATA_BITS'(cfg_q.pulse_threshold);
      REG_TRIGGER_MODE:     prdata_o = DATA_BITS'(cfg_q.trigger_mode);
      REG_CONFIRM_TICKS:    prdata_o = DATA_BITS'(cfg_q.confirm_ticks);
      REG_PULSE_TICKS:      prdata_o = DATA_BITS'(cfg_q.pulse_ticks);
      default:              prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/crs_seq.sv
// Phase machine: command decode, trigger, countdown, LED and firing output.
module crs_seq
  import crs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  logic [2:0]          phase_q, phase_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                led_q, led_d;
  logic                fire_q, fire_d;
  logic                manual;
  logic                trig;
  logic                cnt_zero;
  logic [CNT_BITS-1:0] cnt_dec;
  logic [CNT_BITS-1:0] reload_confirm;
  logic [CNT_BITS-1:0] reload_pulse;

  // Decode the manual command and form the trigger
  always_comb begin
    manual = (item_i.pulse_width > cfg_i.pulse_threshold) ^ cfg_i.channel_reversed;
    if (cfg_i.trigger_mode) begin
      trig = manual & item_i.radio_present;
    end else begin
      trig = manual | ~item_i.radio_present;
    end
  end

  assign cnt_zero       = (cnt_q == '0);
  assign cnt_dec        = cnt_q - CNT_BITS'(1);
  assign reload_confirm = {1'b0, cfg_i.confirm_ticks};
  assign reload_pulse   = {1'b0, cfg_i.pulse_ticks};

  // Advance the phase machine by one tick
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    led_d   = led_q;
    fire_d  = fire_q;
    case (phase_q)
      PH_CONFIRM: begin
        if (trig) begin
          led_d = ~led_q;
          if (cnt_zero) begin
            cnt_d   = reload_pulse;
            phase_d = PH_FIRING;
          end else begin
            cnt_d = cnt_dec;
          end
        end else begin
          led_d   = 1'b0;
          cnt_d   = reload_confirm;
          phase_d = PH_ASCENT;
        end
      end
      PH_FIRING: begin
        led_d  = 1'b1;
        fire_d = 1'b1;
        cnt_d  = cnt_dec;
        if (cnt_zero) begin
          phase_d = PH_END;
        end
      end
      PH_END: begin
        led_d  = 1'b0;
        fire_d = 1'b0;
        if (!trig) begin
          cnt_d   = reload_confirm;
          phase_d = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (manual) begin
          phase_d = PH_CONFIRM;
        end else begin
          cnt_d = reload_confirm;
        end
      end
      default: begin
        // Ascent, and unused codes that behave as ascent
        if (trig) begin
          phase_d = PH_CONFIRM;
        end else begin
          phase_d = PH_ASCENT;
          cnt_d   = reload_confirm;
        end
      end
    endcase
  end

  // Hold state until a tick is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ASCENT;
      cnt_q   <= {1'b0, CONFIRM_RESET};
      led_q   <= 1'b0;
      fire_q  <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      led_q   <= led_d;
      fire_q  <= fire_d;
    end
  end

  assign res_o.fire_out       = fire_d;
  assign res_o.led_level      = led_d;
  assign res_o.phase          = phase_d;
  assign res_o.manual_command = manual;

endmodule

// File: rtl/core/cutdown_release_sequencer_core.sv
// Top level of the cutdown release sequencer: input register, phase machine, result register.
//
// One tick item is accepted per clock cycle while the result side is not stalled, with no
// gap needed between ticks. An accepted tick waits in the input register. When the result
// register is free, the phase machine updates its state and the result register captures
// the values after the tick at the same edge, so the result is offered from that register.
// A stalled result holds the result register and, once the input register is
// also full, the input channel stalls in the same cycle. Configuration is an
// APB-style port with registers at byte addresses 0, 4, 8, 12 and 16.
module cutdown_release_sequencer_core
  import crs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  out_item_t res;
  logic      out_free;
  logic      adv;
  logic      in_take;

  crs_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // Pipeline control: the result register frees when empty or transferred
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign adv        = in_valid_q & out_free;
  assign in_stall_o = in_valid_q & ~out_free;
  assign in_take    = in_valid_i & ~in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (out_free | ~in_valid_q) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  crs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A processed tick always lands in the result register
  a_adv_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("processed tick did not reach the result register");

  // The release output is driven only in firing or end
  a_fire_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.fire_out) |-> (out_q.phase == PH_FIRING || out_q.phase == PH_END))
    else $error("release output high outside firing or end");

  // The release output is never driven with the LED off
  a_fire_led : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.fire_out) |-> out_q.led_level)
    else $error("release output high with the LED off");

  // The input side stalls only while a tick waits in the input register
  a_stall_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with room in the pipeline");

endmodule

// File: tb/release_sequence_monitor.sv
// Monitor for the cutdown release sequencer: predicts each tick's result and compares.
`timescale 1ns / 100ps

module release_sequence_monitor
  import crs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_item_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_item_t            out_data_i,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic                 pready_i,
  input  logic [ADDR_BITS-1:0] paddr_i,
  input  logic [DATA_BITS-1:0] pwdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int PRINT_LIMIT = 100;

  // Shadow registers and sequencer state
  cfg_t                live_cfg;
  logic [2:0]          seq_phase;
  logic [CNT_BITS-1:0] countdown;
  logic                led;
  logic                fire;

  out_item_t predicted_results[$];
  int        mismatches = 0;
  int        results_seen = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_LIMIT)
      $display("[%0t] result %0d %s: got %0d, expected %0d", $time, results_seen, what,
               got, want);
    mismatches++;
  endtask

  // Advance the sequencer by one tick and return the values after it
  function automatic out_item_t advance_tick(input in_item_t tick);
    out_item_t res;
    logic      above;
    logic      manual;
    logic      trig;
    above  = tick.pulse_width > live_cfg.pulse_threshold;
    manual = live_cfg.channel_reversed ? !above : above;
    if (live_cfg.trigger_mode)
      trig = manual && tick.radio_present;
    else
      trig = manual || !tick.radio_present;

    case (seq_phase)
      PH_CONFIRM: begin
        if (trig) begin
          led = ~led;
          if (countdown == '0) begin
            countdown = {1'b0, live_cfg.pulse_ticks};
            seq_phase = PH_FIRING;
          end else begin
            countdown = countdown - 1'b1;
          end
        end else begin
          led       = 1'b0;
          countdown = {1'b0, live_cfg.confirm_ticks};
          seq_phase = PH_ASCENT;
        end
      end
      PH_FIRING: begin
        led  = 1'b1;
        fire = 1'b1;
        // wraps to all ones on the last tick
        if (countdown == '0) seq_phase = PH_END;
        countdown = countdown - 1'b1;
      end
      PH_END: begin
        led  = 1'b0;
        fire = 1'b0;
        if (!trig) begin
          countdown = {1'b0, live_cfg.confirm_ticks};
          seq_phase = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (manual)
          seq_phase = PH_CONFIRM;
        else
          countdown = {1'b0, live_cfg.confirm_ticks};
      end
      default: begin
        if (trig) begin
          seq_phase = PH_CONFIRM;
        end else begin
          seq_phase = PH_ASCENT;
          countdown = {1'b0, live_cfg.confirm_ticks};
        end
      end
    endcase

    res.fire_out       = fire;
    res.led_level      = led;
    res.phase          = seq_phase;
    res.manual_command = manual;
    return res;
  endfunction

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t  want;
    logic [IDX_BITS-1:0] idx;
    if (!rst_ni) begin
      live_cfg.channel_reversed = 1'b0;
      live_cfg.pulse_threshold  = THRESH_RESET;
      live_cfg.trigger_mode     = 1'b0;
      live_cfg.confirm_ticks    = CONFIRM_RESET;
      live_cfg.pulse_ticks      = PULSE_RESET;
      seq_phase = PH_ASCENT;
      countdown = {1'b0, CONFIRM_RESET};
      led       = 1'b0;
      fire      = 1'b0;
      predicted_results.delete();
      pending_o <= 0;
    end else begin
      // Check the result transfer against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result with no tick pending", out_data_i, 0);
        end else begin
          want = predicted_results.pop_front();
          if (out_data_i.fire_out !== want.fire_out)
            report_mismatch("fire_out", out_data_i.fire_out, want.fire_out);
          if (out_data_i.led_level !== want.led_level)
            report_mismatch("led_level", out_data_i.led_level, want.led_level);
          if (out_data_i.phase !== want.phase)
            report_mismatch("phase", out_data_i.phase, want.phase);
          if (out_data_i.manual_command !== want.manual_command)
            report_mismatch("manual_command", out_data_i.manual_command,
                            want.manual_command);
        end
        results_seen++;
      end

      // Predict each accepted tick
      if (in_valid_i && !in_stall_i)
        predicted_results.push_back(advance_tick(in_data_i));

      // Mirror register writes; unknown indexes are ignored
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        idx = paddr_i[ADDR_BITS-1:2];
        case (idx)
          REG_CHANNEL_REVERSED: live_cfg.channel_reversed = pwdata_i[0];
          REG_PULSE_THRESHOLD:  live_cfg.pulse_threshold  = pwdata_i[15:0];
          REG_TRIGGER_MODE:     live_cfg.trigger_mode     = pwdata_i[0];
          REG_CONFIRM_TICKS:    live_cfg.confirm_ticks    = pwdata_i[TIMER_BITS-1:0];
          REG_PULSE_TICKS:      live_cfg.pulse_ticks      = pwdata_i[TIMER_BITS-1:0];
          default: ;
        endcase
      end

      pending_o <= predicted_results.size();
    end
  end

endmodule

// File: tb/cutdown_release_sequencer_core_test.sv
// Top of the cutdown release sequencer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module cutdown_release_sequencer_core_test;
  import crs_pkg::*;

  localparam int IDLE_LIMIT        = 2000;
  localparam int SETTING_COUNT     = 10;
  localparam int TICKS_PER_SETTING = 88;
  localparam int SETTLE_CYCLES     = 4;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_BEAT} stall_style_e;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  in_item_t             in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [ADDR_BITS-1:0] paddr     = '0;
  logic [DATA_BITS-1:0] pwdata    = '0;
  logic                 in_stall;
  logic                 out_valid;
  out_item_t            out_data;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  int fail_count;
  int pending;

  // Stimulus bookkeeping
  cfg_t live_cfg;
  int   burst_left = 0;
  int   run_left   = 0;
  logic run_above  = 1'b0;
  logic run_radio  = 1'b1;

  // Receiver stall pattern
  stall_style_e stall_style = STALL_NONE;
  int           style_left  = 0;
  int           beat_cnt    = 0;

  int idle_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  cutdown_release_sequencer_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  release_sequence_monitor monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Switch the stall style every so often; some stretches never stall
  always @(posedge clk_i) begin
    if (style_left == 0) begin
      stall_style <= stall_style_e'($urandom_range(3, 0));
      style_left  <= $urandom_range(150, 20);
    end else begin
      style_left <= style_left - 1;
    end
    beat_cnt <= beat_cnt + 1;
    case (stall_style)
      STALL_COIN:  out_stall <= 1'($urandom_range(1, 0));
      STALL_HEAVY: out_stall <= ($urandom_range(4, 0) != 0);
      STALL_BEAT:  out_stall <= (beat_cnt % 7) < 3;
      default:     out_stall <= 1'b0;
    endcase
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else begin
      if (idle_cycles == IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Transfer one tick, opening a new burst after a random gap when due
  task automatic send_tick(input logic [15:0] width, input logic radio);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
      gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{pulse_width: width, radio_present: radio};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Hold the sender until every predicted result has come back
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Register write: setup phase, access phase, then the bus returns to idle
  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [31:0] value,
                           input int width);
    logic [31:0] keep;
    keep    = (32'd1 << width) - 1;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom() & ~keep) | (value & keep);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Program a full setting while idle, plus one write to an unused index
  task automatic apply_setting(input cfg_t s);
    logic [IDX_BITS-1:0] spare_idx;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_CHANNEL_REVERSED, s.channel_reversed, 1);
    write_reg(REG_PULSE_THRESHOLD, s.pulse_threshold, 16);
    write_reg(REG_TRIGGER_MODE, s.trigger_mode, 1);
    write_reg(REG_CONFIRM_TICKS, s.confirm_ticks, TIMER_BITS);
    write_reg(REG_PULSE_TICKS, s.pulse_ticks, TIMER_BITS);
    spare_idx = IDX_BITS'($urandom_range(2**IDX_BITS - 1, int'(REG_PULSE_TICKS) + 1));
    write_reg(spare_idx, $urandom(), 32);
    live_cfg = s;
  endtask

  // Width on the requested side of the threshold where one exists, sometimes right at the boundary
  function automatic logic [15:0] pick_width(input logic above, input logic [15:0] thr);
    if ($urandom_range(7, 0) == 0)
      return (above && thr != 16'hFFFF) ? thr + 16'd1 : thr;
    if (above && thr != 16'hFFFF)
      return 16'($urandom_range(65535, int'(thr) + 1));
    return 16'($urandom_range(int'(thr), 0));
  endfunction

  function automatic cfg_t pick_setting(input int k);
    cfg_t s;
    s.channel_reversed = 1'($urandom_range(1, 0));
    s.trigger_mode     = 1'($urandom_range(1, 0));
    s.pulse_threshold  = ($urandom_range(3, 0) == 0) ? {16{s.channel_reversed}}
                                                    : 16'($urandom_range(65535, 0));
    s.confirm_ticks    = TIMER_BITS'($urandom_range(6, 0));
    s.pulse_ticks      = TIMER_BITS'($urandom_range(6, 0));
    case (k)
      0: s = '{channel_reversed: 1'b1, pulse_threshold: 16'd0, trigger_mode: 1'b1,
               confirm_ticks: '0, pulse_ticks: '0};
      1: s = '{channel_reversed: 1'b0, pulse_threshold: 16'hFFFF, trigger_mode: 1'b0,
               confirm_ticks: '1, pulse_ticks: '1};
      2: s = '{channel_reversed: 1'b1, pulse_threshold: 16'hFFFF, trigger_mode: 1'b1,
               confirm_ticks: TIMER_BITS'(2), pulse_ticks: TIMER_BITS'(3)};
      // long firing pulse, left running into the next setting
      3: begin
        s.confirm_ticks = TIMER_BITS'(1);
        s.pulse_ticks   = '1;
      end
      default: ;
    endcase
    return s;
  endfunction

  // Random ticks in runs that hold one level, with some noise mixed in
  task automatic run_ticks(input int count, input int pause_at);
    logic [15:0] width;
    logic        radio;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain();
      if (run_left == 0) begin
        run_left  = ($urandom_range(3, 0) == 0) ? $urandom_range(24, 8) : $urandom_range(6, 1);
        run_above = 1'($urandom_range(1, 0));
        run_radio = ($urandom_range(3, 0) != 0);
      end
      run_left--;
      if ($urandom_range(7, 0) == 0) begin
        width = 16'($urandom());
        radio = 1'($urandom_range(1, 0));
      end else begin
        width = pick_width(run_above, live_cfg.pulse_threshold);
        radio = ($urandom_range(9, 0) == 0) ? ~run_radio : run_radio;
      end
      send_tick(width, radio);
    end
  endtask

  initial begin
    cfg_t quick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    live_cfg = '{channel_reversed: 1'b0, pulse_threshold: THRESH_RESET, trigger_mode: 1'b0,
                 confirm_ticks: CONFIRM_RESET, pulse_ticks: PULSE_RESET};

    // Field extremes and the threshold boundary under reset settings
    send_tick(16'd0, 1'b1);
    send_tick(16'hFFFF, 1'b1);
    send_tick(THRESH_RESET, 1'b1);
    send_tick(THRESH_RESET + 16'd1, 1'b1);
    send_tick(THRESH_RESET + 16'd1, 1'b0);
    send_tick(16'd0, 1'b0);
    send_tick(16'h5555, 1'b1);
    send_tick(16'hAAAA, 1'b0);
    send_tick(16'd0, 1'b1);

    // Walk every phase with the shortest confirm timer
    quick = live_cfg;
    quick.confirm_ticks = '0;
    quick.pulse_ticks   = TIMER_BITS'(1);
    apply_setting(quick);
    send_tick(16'd0, 1'b1);      // reload with the new confirm value
    send_tick(16'hFFFF, 1'b1);   // to confirm
    send_tick(16'hFFFF, 1'b1);   // count expired, to firing
    send_tick(16'd0, 1'b0);
    send_tick(16'd0, 1'b0);      // firing ends, countdown wraps
    send_tick(16'd0, 1'b0);      // end holds while radio is lost
    send_tick(16'd0, 1'b1);      // trigger clear, to wait
    send_tick(16'hFFFF, 1'b0);   // manual re-arm, to confirm
    send_tick(16'd0, 1'b1);      // trigger drops, back to ascent

    for (int k = 0; k < SETTING_COUNT; k++) begin
      apply_setting(pick_setting(k));
      run_ticks(TICKS_PER_SETTING, $urandom_range(TICKS_PER_SETTING - 1, 1));
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
